// File: design/vpd_pkg.sv
// ----------------------------------------------------------------------------
// vpd_pkg: shared types and constants
// Lane result type, CORDIC angle table and conversion constants.
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int          COORD_W   = 16;
  localparam int          BAM_W     = 32;
  localparam int          LANE_W    = 34;
  localparam logic [31:0] BAM_HALF  = 32'h8000_0000;
  localparam logic [31:0] GAIN_Q32  = 32'd2608131496;
  localparam logic [23:0] TWO_PI_Q21 = 24'd13176795;
  localparam logic [15:0] DEG_FULL  = 16'd46080;
  localparam logic [16:0] RAD_LIMIT = 17'd51472;
  localparam logic [16:0] DEG_LIMIT = 17'd46080;
  localparam logic [15:0] MAG_MAX   = 16'hFFFF;

  typedef struct packed {
    logic        zero;
    logic [31:0] mag_x;
    logic [31:0] bam;
  } lane_res_t;

  // atan(2^-i) as a binary angle, full circle = 2^32
  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'd536870912;
      1:  t = 32'd316933406;
      2:  t = 32'd167458907;
      3:  t = 32'd85004756;
      4:  t = 32'd42667331;
      5:  t = 32'd21354465;
      6:  t = 32'd10679838;
      7:  t = 32'd5340245;
      8:  t = 32'd2670163;
      9:  t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

// File: design/vpd_in_if.sv
// ----------------------------------------------------------------------------
// vpd_in_if: input item channel
// Valid/ready channel carrying two vectors in signed Q8.8.
// ----------------------------------------------------------------------------
interface vpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

// File: design/vpd_out_if.sv
// ----------------------------------------------------------------------------
// vpd_out_if: result item channel
// Valid/ready channel carrying polar forms, dot product and angle between.
// ----------------------------------------------------------------------------
interface vpd_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        first_magnitude;
  logic [15:0]        first_angle_rad;
  logic [15:0]        first_angle_deg;
  logic [15:0]        second_magnitude;
  logic [15:0]        second_angle_rad;
  logic [15:0]        second_angle_deg;
  logic signed [32:0] dot_product;
  logic [14:0]        between_rad;
  logic [14:0]        between_deg;
  logic               zero_vector;

  modport source (output valid, first_magnitude, first_angle_rad, first_angle_deg,
                  second_magnitude, second_angle_rad, second_angle_deg,
                  dot_product, between_rad, between_deg, zero_vector,
                  input ready);
  modport sink   (input valid, first_magnitude, first_angle_rad, first_angle_deg,
                  second_magnitude, second_angle_rad, second_angle_deg,
                  dot_product, between_rad, between_deg, zero_vector,
                  output ready);
endinterface

// File: design/vpd_lane.sv
// ----------------------------------------------------------------------------
// vpd_lane: pipelined vectoring CORDIC lane
// Pre-rotates into the right half plane, then one registered stage per
// micro-rotation; yields unscaled length and binary angle.
// ----------------------------------------------------------------------------
module vpd_lane #(
  parameter int STAGES = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  x_i,
  input  logic signed [15:0]  y_i,
  output vpd_pkg::lane_res_t  res_o
);
  import vpd_pkg::*;

  logic signed [LANE_W-1:0] x_r [0:STAGES];
  logic signed [LANE_W-1:0] y_r [0:STAGES];
  logic [BAM_W-1:0]         z_r [0:STAGES];
  logic                     zero_r [0:STAGES];

  logic signed [LANE_W-1:0] x_ext;
  logic signed [LANE_W-1:0] y_ext;

  // scale coordinates by 2^14
  assign x_ext = {{(LANE_W-COORD_W-14){x_i[15]}}, x_i, 14'b0};
  assign y_ext = {{(LANE_W-COORD_W-14){y_i[15]}}, y_i, 14'b0};

  // rotate by pi when x is negative
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[15]) begin
        x_r[0] <= -x_ext;
        y_r[0] <= -y_ext;
        z_r[0] <= BAM_HALF;
      end else begin
        x_r[0] <= x_ext;
        y_r[0] <= y_ext;
        z_r[0] <= '0;
      end
    end
  end

  // drive y toward zero, one micro-rotation per stage
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [LANE_W-1:0] dx;
    logic signed [LANE_W-1:0] dy;
    assign dx = x_r[g] >>> g;
    assign dy = y_r[g] >>> g;
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[g+1] <= zero_r[g];
        if (y_r[g][LANE_W-1]) begin
          x_r[g+1] <= x_r[g] - dy;
          y_r[g+1] <= y_r[g] + dx;
          z_r[g+1] <= z_r[g] - atan_bam(g);
        end else begin
          x_r[g+1] <= x_r[g] + dy;
          y_r[g+1] <= y_r[g] - dx;
          z_r[g+1] <= z_r[g] + atan_bam(g);
        end
      end
    end
  end

  assign res_o.zero  = zero_r[STAGES];
  assign res_o.mag_x = x_r[STAGES][31:0];
  assign res_o.bam   = z_r[STAGES];

endmodule

// File: design/vpd_dot.sv
// ----------------------------------------------------------------------------
// vpd_dot: dot product with matching delay
// Two registered products, a registered sum, then a delay line that lines
// the sum up with the CORDIC lanes.
// ----------------------------------------------------------------------------
module vpd_dot #(
  parameter int DEPTH = 17
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] x1_i,
  input  logic signed [15:0] y1_i,
  input  logic signed [15:0] x2_i,
  input  logic signed [15:0] y2_i,
  output logic signed [32:0] dot_o
);
  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic signed [32:0] dly_r [1:DEPTH-1];

  // multiply, then add
  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= x1_i * x2_i;
      py_r     <= y1_i * y2_i;
      dly_r[1] <= 33'(px_r) + 33'(py_r);
    end
  end

  // hold the sum until the lanes finish
  for (genvar g = 2; g < DEPTH; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) dly_r[g] <= dly_r[g-1];
    end
  end

  assign dot_o = dly_r[DEPTH-1];

endmodule

// File: design/vpd_merge.sv
// ----------------------------------------------------------------------------
// vpd_merge: combine lane results
// Scales lengths, converts binary angles to radians and degrees, folds the
// angle difference into [0, pi]; three registered stages.
// ----------------------------------------------------------------------------
module vpd_merge (
  input  logic               clk,
  input  logic               en,
  input  vpd_pkg::lane_res_t a_i,
  input  vpd_pkg::lane_res_t b_i,
  input  logic signed [32:0] dot_i,
  output logic [15:0]        mag_a_o,
  output logic [15:0]        rad_a_o,
  output logic [15:0]        deg_a_o,
  output logic [15:0]        mag_b_o,
  output logic [15:0]        rad_b_o,
  output logic [15:0]        deg_b_o,
  output logic signed [32:0] dot_o,
  output logic [14:0]        btw_rad_o,
  output logic [14:0]        btw_deg_o,
  output logic               zero_o
);
  import vpd_pkg::*;

  // stage 1
  logic [63:0]        mp_a_r, mp_b_r;
  logic [55:0]        rp_a_r, rp_b_r;
  logic [47:0]        gp_a_r, gp_b_r;
  logic [31:0]        d_r;
  logic               za1_r, zb1_r;
  logic signed [32:0] dot1_r;
  logic [31:0]        diff;

  assign diff = a_i.bam - b_i.bam;

  // multiply and fold the difference
  always_ff @(posedge clk) begin
    if (en) begin
      mp_a_r <= 64'(a_i.mag_x) * 64'(GAIN_Q32);
      mp_b_r <= 64'(b_i.mag_x) * 64'(GAIN_Q32);
      rp_a_r <= 56'(a_i.bam) * 56'(TWO_PI_Q21);
      rp_b_r <= 56'(b_i.bam) * 56'(TWO_PI_Q21);
      gp_a_r <= 48'(a_i.bam) * 48'(DEG_FULL);
      gp_b_r <= 48'(b_i.bam) * 48'(DEG_FULL);
      d_r    <= (diff > BAM_HALF) ? (32'd0 - diff) : diff;
      za1_r  <= a_i.zero;
      zb1_r  <= b_i.zero;
      dot1_r <= dot_i;
    end
  end

  // stage 2
  logic [16:0]        rd_a, rd_b, gd_a, gd_b;
  logic [19:0]        md_a, md_b;
  logic [15:0]        mag_a2_r, mag_b2_r, rad_a2_r, rad_b2_r, deg_a2_r, deg_b2_r;
  logic [55:0]        drp_r;
  logic [47:0]        dgp_r;
  logic               za2_r, zb2_r;
  logic signed [32:0] dot2_r;
  logic [64:0]        msum_a, msum_b;
  logic [56:0]        rsum_a, rsum_b;
  logic [48:0]        gsum_a, gsum_b;

  assign msum_a = 65'(mp_a_r) + (65'd1 << 45);
  assign msum_b = 65'(mp_b_r) + (65'd1 << 45);
  assign md_a   = {1'b0, msum_a[64:46]};
  assign md_b   = {1'b0, msum_b[64:46]};
  assign rsum_a = 57'(rp_a_r) + (57'd1 << 39);
  assign rsum_b = 57'(rp_b_r) + (57'd1 << 39);
  assign rd_a   = rsum_a[56:40];
  assign rd_b   = rsum_b[56:40];
  assign gsum_a = 49'(gp_a_r) + (49'd1 << 31);
  assign gsum_b = 49'(gp_b_r) + (49'd1 << 31);
  assign gd_a   = gsum_a[48:32];
  assign gd_b   = gsum_b[48:32];

  // round, saturate, wrap the full circle, clear zero vectors
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a2_r <= (md_a > 20'(MAG_MAX)) ? MAG_MAX : md_a[15:0];
      mag_b2_r <= (md_b > 20'(MAG_MAX)) ? MAG_MAX : md_b[15:0];
      rad_a2_r <= (za1_r || rd_a >= RAD_LIMIT) ? 16'd0 : rd_a[15:0];
      rad_b2_r <= (zb1_r || rd_b >= RAD_LIMIT) ? 16'd0 : rd_b[15:0];
      deg_a2_r <= (za1_r || gd_a >= DEG_LIMIT) ? 16'd0 : gd_a[15:0];
      deg_b2_r <= (zb1_r || gd_b >= DEG_LIMIT) ? 16'd0 : gd_b[15:0];
      drp_r    <= 56'(d_r) * 56'(TWO_PI_Q21);
      dgp_r    <= 48'(d_r) * 48'(DEG_FULL);
      za2_r    <= za1_r;
      zb2_r    <= zb1_r;
      dot2_r   <= dot1_r;
    end
  end

  // stage 3: output register
  logic [56:0] drsum;
  logic [48:0] dgsum;

  assign drsum = 57'(drp_r) + (57'd1 << 39);
  assign dgsum = 49'(dgp_r) + (49'd1 << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_o   <= mag_a2_r;
      mag_b_o   <= mag_b2_r;
      rad_a_o   <= rad_a2_r;
      rad_b_o   <= rad_b2_r;
      deg_a_o   <= deg_a2_r;
      deg_b_o   <= deg_b2_r;
      dot_o     <= dot2_r;
      zero_o    <= za2_r || zb2_r;
      btw_rad_o <= (za2_r || zb2_r) ? 15'd0 : drsum[54:40];
      btw_deg_o <= (za2_r || zb2_r) ? 15'd0 : dgsum[46:32];
    end
  end

endmodule

// File: design/vector_pair_polar_and_dot_unit.sv
// Throughput: one item per cycle; two CORDIC lanes and the dot unit are fully
// pipelined, and the whole pipe holds while a result waits untaken.
// Reset: rst_n (synchronous, active low) clears the valid bits only; no state.
// ----------------------------------------------------------------------------
// vector_pair_polar_and_dot_unit: polar form, dot product, angle between
// Two CORDIC lanes, one per vector, a dot product unit and a merging stage.
// ----------------------------------------------------------------------------
module vector_pair_polar_and_dot_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  vpd_in_if.sink      in_ch,
  vpd_out_if.source   out_ch
);
  import vpd_pkg::*;

  localparam int LAT = CORDIC_STAGES + 4;

  logic            en;
  logic [LAT-1:0]  vld_r;
  logic [LAT-1:0]  vld_nxt;
  lane_res_t       res_a;
  lane_res_t       res_b;
  logic signed [32:0] dot;

  // advance the pipe unless a result is stalled at the output
  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld_r[LAT-1];

  assign vld_nxt = {vld_r[LAT-2:0], in_ch.valid};

  // track which stages hold an item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  vpd_lane #(.STAGES(CORDIC_STAGES)) u_lane_a (
    .clk (clk), .en (en), .x_i (in_ch.first_x), .y_i (in_ch.first_y), .res_o (res_a)
  );

  vpd_lane #(.STAGES(CORDIC_STAGES)) u_lane_b (
    .clk (clk), .en (en), .x_i (in_ch.second_x), .y_i (in_ch.second_y), .res_o (res_b)
  );

  vpd_dot #(.DEPTH(CORDIC_STAGES + 1)) u_dot (
    .clk (clk), .en (en),
    .x1_i (in_ch.first_x), .y1_i (in_ch.first_y),
    .x2_i (in_ch.second_x), .y2_i (in_ch.second_y),
    .dot_o (dot)
  );

  vpd_merge u_merge (
    .clk       (clk),
    .en        (en),
    .a_i       (res_a),
    .b_i       (res_b),
    .dot_i     (dot),
    .mag_a_o   (out_ch.first_magnitude),
    .rad_a_o   (out_ch.first_angle_rad),
    .deg_a_o   (out_ch.first_angle_deg),
    .mag_b_o   (out_ch.second_magnitude),
    .rad_b_o   (out_ch.second_angle_rad),
    .deg_b_o   (out_ch.second_angle_deg),
    .dot_o     (out_ch.dot_product),
    .btw_rad_o (out_ch.between_rad),
    .btw_deg_o (out_ch.between_deg),
    .zero_o    (out_ch.zero_vector)
  );

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: vector pair polar and dot unit
// Drives vector pairs through the input channel, predicts each result with a
// bit-exact CORDIC model and compares every result field in order.
// ----------------------------------------------------------------------------
module testbench;
  import vpd_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 4;

  typedef struct packed {
    logic [15:0] m1, r1, d1, m2, r2, d2;
    logic [32:0] dot;
    logic [14:0] br, bd;
    logic        zv;
  } polar_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vpd_in_if  in_ch();
  vpd_out_if out_ch();

  vector_pair_polar_and_dot_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  polar_res_t expected_q[$];
  int mismatch_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Own copy of the arctangent table, binary angle units
  function automatic longint arctan_step(int i);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  // Vectoring CORDIC: binary angle and Q8.8 magnitude
  function automatic void polar_of(input longint x, input longint y,
                                   output logic [31:0] bam, output logic [15:0] mag);
    longint z, dx, dy;
    logic [63:0] base, prod;
    z = 0;
    base = 0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 64'h8000_0000;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y < 0) begin
        x = x - dy; y = y + dx; z = z - arctan_step(i);
      end else begin
        x = x + dy; y = y - dx; z = z + arctan_step(i);
      end
    end
    bam = 32'(base + 64'(z));
    prod = (64'(x) * 64'd2608131496 + (64'd1 << 45)) >> 46;
    mag = (prod > 65535) ? 16'hFFFF : prod[15:0];
  endfunction

  function automatic logic [63:0] bam_rad(logic [31:0] b);
    return (64'(b) * 64'd13176795 + (64'd1 << 39)) >> 40;
  endfunction

  function automatic logic [63:0] bam_deg(logic [31:0] b);
    return (64'(b) * 64'd46080 + (64'd1 << 31)) >> 32;
  endfunction

  function automatic polar_res_t predict_polar(logic signed [15:0] x1, y1, x2, y2);
    polar_res_t res;
    logic [31:0] b1, b2, d;
    logic [15:0] m1, m2;
    logic [63:0] r, g;
    logic z1, z2;
    longint dotv;
    b1 = 0; b2 = 0; m1 = 0; m2 = 0;
    z1 = (x1 == 0 && y1 == 0);
    z2 = (x2 == 0 && y2 == 0);
    if (!z1) polar_of(longint'(x1), longint'(y1), b1, m1);
    if (!z2) polar_of(longint'(x2), longint'(y2), b2, m2);
    dotv = longint'(x1) * longint'(x2) + longint'(y1) * longint'(y2);
    res.m1 = m1;
    r = bam_rad(b1); g = bam_deg(b1);
    res.r1 = (r >= 51472) ? 16'd0 : r[15:0];
    res.d1 = (g >= 46080) ? 16'd0 : g[15:0];
    res.m2 = m2;
    r = bam_rad(b2); g = bam_deg(b2);
    res.r2 = (r >= 51472) ? 16'd0 : r[15:0];
    res.d2 = (g >= 46080) ? 16'd0 : g[15:0];
    res.dot = dotv[32:0];
    if (z1 || z2) begin
      res.br = 0; res.bd = 0; res.zv = 1'b1;
    end else begin
      d = b1 - b2;
      if (d > 32'h8000_0000) d = -d;
      r = bam_rad(d); g = bam_deg(d);
      res.br = r[14:0]; res.bd = g[14:0]; res.zv = 1'b0;
    end
    return res;
  endfunction

  // Send one item, idling at random before it
  task automatic send_pair(logic [15:0] x1, y1, x2, y2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.first_x  <= x1;
    in_ch.first_y  <= y1;
    in_ch.second_x <= x2;
    in_ch.second_y <= y2;
    expected_q.push_back(predict_polar(x1, y1, x2, y2));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold it low for one cycle
  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random coordinate: mostly full range, sometimes an extreme or zero
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] c[10] = '{16'h0000, 16'h0100, 16'hFF00, 16'h7FFF, 16'h8000,
                          16'h0001, 16'hFFFF, 16'h0080, 16'h5555, 16'hAAAA};
    // extremes, zero vectors, axes and all quadrants
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h0000, 16'h0000, 16'h0100, 16'h0100);
    send_pair(16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_pair(16'hFF00, 16'hFF00, 16'h0100, 16'h0100);
    send_pair(16'hFF00, 16'hFFFF, 16'h0100, 16'hFFFF);
    send_pair(16'h0100, 16'hFFFF, 16'hFF00, 16'h0001);
    send_pair(16'hFF00, 16'h0000, 16'h0000, 16'hFF00);
    send_pair(16'h0000, 16'h0100, 16'hFF00, 16'h0100);
    for (int i = 0; i < 10; i++)
      send_pair(c[i], c[(i + 3) % 10], c[(i + 7) % 10], c[(i + 1) % 10]);
    drop_valid();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    drop_valid();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    polar_res_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.first_magnitude, out_ch.first_angle_rad, out_ch.first_angle_deg,
              out_ch.second_magnitude, out_ch.second_angle_rad,
              out_ch.second_angle_deg, out_ch.dot_product, out_ch.between_rad,
              out_ch.between_deg, out_ch.zero_vector};
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.first_x  <= '0;
    in_ch.first_y  <= '0;
    in_ch.second_x <= '0;
    in_ch.second_y <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 7; recv_idle_pct = 83;
    test_directed();
    test_random(580);
    send_idle_pct = 83; recv_idle_pct = 7;
    test_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(600);
    drain();
    if (mismatch_cnt == 0 && expected_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Hard stop
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
design/vpd_pkg.sv
design/vpd_in_if.sv
design/vpd_out_if.sv
design/vpd_lane.sv
design/vpd_dot.sv
design/vpd_merge.sv
design/vector_pair_polar_and_dot_unit.sv
verif/testbench.sv
